[sv/atkinson_dither_assert.svh]
// Assertion macros used by the dither checker.
`ifndef ATKINSON_DITHER_ASSERT_SVH
`define ATKINSON_DITHER_ASSERT_SVH

// Same-cycle implication, muted while reset is high.
`define ATKD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted while reset is high.
`define ATKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/atkd_pkg.sv]
// Shared types, constants and helpers for the Atkinson dither block.
package atkd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_CFG_W = 13;
   localparam int ROW_W       = 16;
   localparam int PIX_W       = 8;
   localparam int ERR_W       = 5;
   localparam int CSR_DATA_W  = 16;

   localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

   // Reset values of the image size registers
   localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd480;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // Position of one pixel and the edge flags derived from it
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             x_ge1;
      logic             x_ge2;
      logic             y_ge1;
      logic             y_ge2;
      logic             last_col;
      logic             last_img;
   } pos_type;

   // One line-store entry: errors of the row above and two rows above
   typedef struct packed {
      logic signed [ERR_W-1:0] above;
      logic signed [ERR_W-1:0] two_above;
   } line_entry_type;

   // Add a signed error to a pixel, clamped to 0..255
   function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] base,
                                                input logic signed [ERR_W-1:0] err);
      logic signed [PIX_W+1:0] sum;
      sum = $signed({2'b00, base}) + (PIX_W+2)'(err);
      if (sum[PIX_W+1]) begin
         return PIX_BLACK;
      end else if (sum[PIX_W]) begin
         return PIX_WHITE;
      end else begin
         return sum[PIX_W-1:0];
      end
   endfunction

endpackage

[sv/atkd_pos.sv]
// Raster position counters and image edge flags.
module atkd_pos (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [atkd_pkg::WIDTH_CFG_W-1:0] image_width,
   input  logic [atkd_pkg::ROW_W-1:0]       image_height,
   output atkd_pkg::pos_type                pos
);
   import atkd_pkg::*;

   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [WIDTH_CFG_W-1:0] width_eff;
   logic [ROW_W-1:0]       height_eff;
   logic                   last_col;
   logic                   last_row;

   // Zero acts as one, width saturates at the line-store depth
   always_comb begin
      if (image_width == '0) begin
         width_eff = WIDTH_CFG_W'(1);
      end else if (image_width > WIDTH_CFG_W'(MAX_WIDTH)) begin
         width_eff = WIDTH_CFG_W'(MAX_WIDTH);
      end else begin
         width_eff = image_width;
      end
      height_eff = (image_height == '0) ? ROW_W'(1) : image_height;
   end

   // A column or row at or past the limit ends the row or image
   assign last_col = ({1'b0, col_ff} + (COL_W+1)'(1)) >= (COL_W+1)'(width_eff);
   assign last_row = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, height_eff};

   always_comb begin
      pos.col      = col_ff;
      pos.x_ge1    = |col_ff;
      pos.x_ge2    = |col_ff[COL_W-1:1];
      pos.y_ge1    = |row_ff;
      pos.y_ge2    = |row_ff[ROW_W-1:1];
      pos.last_col = last_col;
      pos.last_img = last_col & last_row;
   end

   // Advance on each accepted request
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[sv/atkd_diffuse.sv]
// Error gathering, threshold and new error for one pixel.
module atkd_diffuse (
   input  logic [atkd_pkg::PIX_W-1:0]        pixel_in,
   input  atkd_pkg::pos_type                 pos,
   input  logic signed [atkd_pkg::ERR_W-1:0] err_two_above,
   input  logic signed [atkd_pkg::ERR_W-1:0] err_above_left,
   input  logic signed [atkd_pkg::ERR_W-1:0] err_above,
   input  logic signed [atkd_pkg::ERR_W-1:0] err_above_right,
   input  logic signed [atkd_pkg::ERR_W-1:0] err_left_two,
   input  logic signed [atkd_pkg::ERR_W-1:0] err_left_one,
   output logic [atkd_pkg::PIX_W-1:0]        pixel_out,
   output logic signed [atkd_pkg::ERR_W-1:0] err_out
);
   import atkd_pkg::*;

   logic [PIX_W-1:0]      adj;
   logic [PIX_W-1:0]      quant;
   logic signed [PIX_W:0] diff;
   logic signed [PIX_W:0] diff_shr;

   // Errors join in the order their source pixels were processed
   always_comb begin
      adj = pixel_in;
      if (pos.y_ge2) begin
         adj = sat_add(adj, err_two_above);
      end
      if (pos.y_ge1) begin
         if (pos.x_ge1) begin
            adj = sat_add(adj, err_above_left);
         end
         adj = sat_add(adj, err_above);
         if (!pos.last_col) begin
            adj = sat_add(adj, err_above_right);
         end
      end
      if (pos.x_ge2) begin
         adj = sat_add(adj, err_left_two);
      end
      if (pos.x_ge1) begin
         adj = sat_add(adj, err_left_one);
      end
   end

   // Threshold at mid-gray; error is an eighth of the residue, floored
   always_comb begin
      quant    = adj[PIX_W-1] ? PIX_WHITE : PIX_BLACK;
      diff     = $signed({1'b0, adj}) - $signed({1'b0, quant});
      diff_shr = diff >>> 3;
   end

   assign pixel_out = quant;
   assign err_out   = diff_shr[ERR_W-1:0];

endmodule

[sv/atkd_line_mem.sv]
// Line store of the errors one and two rows up, one write and two reads.
module atkd_line_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [atkd_pkg::COL_W-1:0] wr_addr,
   input  atkd_pkg::line_entry_type   wr_data,
   input  logic                       rd_en,
   input  logic [atkd_pkg::COL_W-1:0] rd_addr_a,
   input  logic [atkd_pkg::COL_W-1:0] rd_addr_b,
   output atkd_pkg::line_entry_type   rd_data_a,
   output atkd_pkg::line_entry_type   rd_data_b
);
   import atkd_pkg::*;

   line_entry_type mem [MAX_WIDTH];
   line_entry_type rd_a_ff;
   line_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered reads; a write to the same entry in the same cycle wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[sv/atkinson_dither.sv]
// Atkinson error-diffusion dither, top level.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   req      | req_valid/stall    | req_pixel_in
//   rsp      | rsp_valid/stall    | rsp_pixel_out, rsp_last_of_image
//   csr      | csr_we             | csr_index, csr_wdata
//
// One pixel per clock sustained while the output is not stalled. A request is
// registered at acceptance, its line-store entries are read in the same
// edge, and its result moves into the output register as the input stage
// advances. Reset is synchronous; the line store is not cleared, since each
// entry is written by one row before the next row reads it. rsp_stall holds
// the output register and raises req_stall in the same cycle only when the
// input stage is full.
module atkinson_dither (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [atkd_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [atkd_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic                              rsp_last_of_image,
   input  logic                              csr_we,
   input  atkd_pkg::csr_index_type           csr_index,
   input  logic [atkd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import atkd_pkg::*;

   // configuration
   logic [WIDTH_CFG_W-1:0] width_ff;
   logic [ROW_W-1:0]       height_ff;

   // input stage
   logic                   s1_valid_ff;
   logic [PIX_W-1:0]       s1_pixel_ff;
   pos_type                s1_pos_ff;

   // output stage
   logic                   rsp_valid_ff;
   logic [PIX_W-1:0]       rsp_pixel_ff;
   logic                   rsp_last_ff;

   // running errors
   logic signed [ERR_W-1:0] left_one_ff;
   logic signed [ERR_W-1:0] left_two_ff;
   logic signed [ERR_W-1:0] prev_above_ff;

   logic                   req_accept;
   logic                   s1_adv;
   pos_type                pos;
   logic [COL_W-1:0]       rd_addr_next;
   line_entry_type         entry_next;
   line_entry_type         entry_cur;
   line_entry_type         wr_entry;
   logic [PIX_W-1:0]       pix_out;
   logic signed [ERR_W-1:0] err_new;

   // Handshake
   assign s1_adv     = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~s1_adv;
   assign req_accept = req_valid & ~req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[ROW_W-1:0];
         endcase
      end
   end

   atkd_pos u_pos (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .pos          (pos)
   );

   // Fetch entries x and x+1 as the request is taken
   assign rd_addr_next = pos.col + COL_W'(1);

   // Entry x becomes the new error over the old above error
   always_comb begin
      wr_entry.above     = err_new;
      wr_entry.two_above = entry_cur.above;
   end

   atkd_line_mem u_line_mem (
      .clock     (clock),
      .wr_en     (s1_adv),
      .wr_addr   (s1_pos_ff.col),
      .wr_data   (wr_entry),
      .rd_en     (req_accept),
      .rd_addr_a (rd_addr_next),
      .rd_addr_b (pos.col),
      .rd_data_a (entry_next),
      .rd_data_b (entry_cur)
   );

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel_in;
         s1_pos_ff   <= pos;
      end
   end

   atkd_diffuse u_diffuse (
      .pixel_in        (s1_pixel_ff),
      .pos             (s1_pos_ff),
      .err_two_above   (entry_cur.two_above),
      .err_above_left  (prev_above_ff),
      .err_above       (entry_cur.above),
      .err_above_right (entry_next.above),
      .err_left_two    (left_two_ff),
      .err_left_one    (left_one_ff),
      .pixel_out       (pix_out),
      .err_out         (err_new)
   );

   // Running errors move on as each pixel leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         left_one_ff <= '0;
         left_two_ff <= '0;
      end else if (s1_adv) begin
         left_one_ff <= err_new;
         left_two_ff <= left_one_ff;
      end
   end

   // Above error of this column serves the next one as above-left
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         prev_above_ff <= entry_cur.above;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (~rsp_valid_ff | ~rsp_stall) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_pixel_ff <= pix_out;
         rsp_last_ff  <= s1_pos_ff.last_img;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_out     = rsp_pixel_ff;
   assign rsp_last_of_image = rsp_last_ff;

endmodule

[sv/atkd_checker.sv]
// Port-level checks for the dither block and their binding.
`include "atkinson_dither_assert.svh"

module atkd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [atkd_pkg::PIX_W-1:0]      rsp_pixel_out,
   input  logic                            rsp_last_of_image
);
   import atkd_pkg::*;

   logic [1:0] inflight_ff, inflight_in;
   logic       req_acc;
   logic       rsp_acc;

   // Requests taken but not yet answered
   assign req_acc     = req_valid & ~req_stall;
   assign rsp_acc     = rsp_valid & ~rsp_stall;
   assign inflight_in = inflight_ff + 2'(req_acc) - 2'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   `ATKD_ASSERT_NOW(a_bilevel, clock, reset, rsp_valid,
      (rsp_pixel_out == PIX_WHITE) || (rsp_pixel_out == PIX_BLACK), "pixel not bilevel")

   `ATKD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_last_of_image), "stalled response moved")

   `ATKD_ASSERT_NOW(a_depth, clock, reset, 1'b1, inflight_ff != 2'd3, "more than two requests held")

   `ATKD_ASSERT_NOW(a_no_phantom, clock, reset, rsp_valid, inflight_ff != 2'd0, "response without request")

endmodule

bind atkinson_dither atkd_checker u_atkd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_pixel_out     (rsp_pixel_out),
   .rsp_last_of_image (rsp_last_of_image)
);

[bench/atkinson_dither_test.sv]
// Self-checking bench for the Atkinson dither block: scripted and random pixels.
module atkinson_dither_test;
   timeunit 1ns;
   timeprecision 1ps;

   import atkd_pkg::*;

   localparam int RANDOM_PIXELS = 1650;
   localparam int QUIET_LIMIT   = 1000;   // cycles with no transfer at all
   localparam int HOLD_CYCLES   = 60;     // long receiver hold-off

   typedef enum logic [1:0] {
      STEP_PIXEL,
      STEP_WIDTH,
      STEP_HEIGHT
   } step_kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } dither_out_type;

   typedef struct packed {
      step_kind_type    kind;
      logic [15:0]      value;
      logic             typed;
      logic [PIX_W-1:0] pix;
      logic             last;
   } script_step_type;

   // Opening script; typed rows carry their own expected result
   localparam script_step_type SCRIPT [25] = '{
      '{STEP_PIXEL,  16'd128,   1'b1, PIX_WHITE, 1'b0},  // first pixel, no errors yet
      '{STEP_PIXEL,  16'd127,   1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd0,     1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd255,   1'b0, PIX_BLACK, 1'b0},
      '{STEP_HEIGHT, 16'h0000,  1'b0, PIX_BLACK, 1'b0},  // zero height, mid-image
      '{STEP_WIDTH,  16'hE000,  1'b0, PIX_BLACK, 1'b0},  // zero width, upper bits ignored
      '{STEP_PIXEL,  16'd200,   1'b0, PIX_BLACK, 1'b0},  // column past width ends image
      '{STEP_PIXEL,  16'd127,   1'b1, PIX_BLACK, 1'b1},  // 1x1 images: plain threshold
      '{STEP_PIXEL,  16'd128,   1'b1, PIX_WHITE, 1'b1},
      '{STEP_PIXEL,  16'd0,     1'b1, PIX_BLACK, 1'b1},
      '{STEP_PIXEL,  16'd255,   1'b1, PIX_WHITE, 1'b1},
      '{STEP_WIDTH,  16'hFFFF,  1'b0, PIX_BLACK, 1'b0},  // width saturates at the maximum
      '{STEP_HEIGHT, 16'hFFFF,  1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd255,   1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd0,     1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd255,   1'b0, PIX_BLACK, 1'b0},
      '{STEP_WIDTH,  16'd2,     1'b0, PIX_BLACK, 1'b0},  // shrink mid-row
      '{STEP_PIXEL,  16'd64,    1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd255,   1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd0,     1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd128,   1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd127,   1'b0, PIX_BLACK, 1'b0},
      '{STEP_HEIGHT, 16'd3,     1'b0, PIX_BLACK, 1'b0},  // current row becomes the last
      '{STEP_PIXEL,  16'd0,     1'b0, PIX_BLACK, 1'b0},
      '{STEP_PIXEL,  16'd255,   1'b0, PIX_BLACK, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_last_of_image;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = REG_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: image size, error line stores, recent errors, position
   logic [WIDTH_CFG_W-1:0]  cfg_width  = WIDTH_RESET;
   logic [ROW_W-1:0]        cfg_height = HEIGHT_RESET;
   logic signed [ERR_W-1:0] line_prev  [MAX_WIDTH];
   logic signed [ERR_W-1:0] line_prev2 [MAX_WIDTH];
   logic signed [ERR_W-1:0] err_left1 = '0;
   logic signed [ERR_W-1:0] err_left2 = '0;
   logic [COL_W-1:0]        col_pos = '0;
   logic [ROW_W-1:0]        row_pos = '0;

   dither_out_type expected_dots [$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;
   bit          hold_pending = 1'b0;

   atkinson_dither uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_out     (rsp_pixel_out),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t, result %0d: %s got %0d, expected %0d",
               $time, results_seen, what, got, want);
      mismatches++;
   endtask

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic logic [PIX_W-1:0] clamp_add(input logic [PIX_W-1:0] base,
                                                  input logic signed [ERR_W-1:0] err);
      int sum;
      sum = int'(base) + int'(err);
      if (sum < 0) return PIX_BLACK;
      if (sum > 255) return PIX_WHITE;
      return sum[PIX_W-1:0];
   endfunction

   // Gather neighbor errors, threshold, and push this pixel's error onward
   function automatic dither_out_type dither_pixel(input logic [PIX_W-1:0] raw);
      int unsigned             w;
      int unsigned             h;
      logic [COL_W-1:0]        x;
      logic [ROW_W-1:0]        y;
      bit                      last_col;
      bit                      last_row;
      logic [PIX_W-1:0]        v;
      logic signed [9:0]       diff;
      logic signed [ERR_W-1:0] err;
      dither_out_type          res;
      w = eff_width();
      h = (cfg_height == 0) ? 1 : cfg_height;
      x = col_pos;
      y = row_pos;
      last_col = (x + 1 >= w);
      last_row = (y + 1 >= h);

      v = raw;
      if (y >= 2) v = clamp_add(v, line_prev2[x]);
      if (y >= 1) begin
         if (x >= 1) v = clamp_add(v, line_prev[x-1]);
         v = clamp_add(v, line_prev[x]);
         if (!last_col) v = clamp_add(v, line_prev[x+1]);
      end
      if (x >= 2) v = clamp_add(v, err_left2);
      if (x >= 1) v = clamp_add(v, err_left1);

      res.pixel = (v >= 128) ? PIX_WHITE : PIX_BLACK;
      diff = $signed({2'b00, v}) - $signed({2'b00, res.pixel});
      diff = diff >>> 3;   // floor division by 8
      err = diff[ERR_W-1:0];

      // Entry x-1 of the row above has now been read for the last time
      if (x >= 1) begin
         line_prev2[x-1] = line_prev[x-1];
         line_prev[x-1] = err_left1;
      end
      if (last_col) begin
         line_prev2[x] = line_prev[x];
         line_prev[x] = err;
      end
      err_left2 = err_left1;
      err_left1 = err;

      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : y + 1'b1;
      end else begin
         col_pos = x + 1'b1;
      end
      res.last = last_col && last_row;
      return res;
   endfunction

   // Offer one request; called and returning at a falling edge
   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                             input dither_out_type typed_exp);
      dither_out_type predicted;
      if (gaps_on && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = dither_pixel(pix);
      expected_dots.push_back(typed ? typed_exp : predicted);
      @(negedge clock);
   endtask

   // Stop offering and wait until every result is back
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_dots.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) cfg_width = data[WIDTH_CFG_W-1:0];
      else cfg_height = data[ROW_W-1:0];
      @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= stalls_on && ($urandom_range(99) < 8);
      end
   end

   // Compare each result with the oldest prediction
   always @(posedge clock) begin : check_results
      dither_out_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_dots.size() == 0) begin
            report_mismatch("result with nothing pending, pixel_out", rsp_pixel_out, -1);
         end else begin
            want = expected_dots.pop_front();
            if (rsp_pixel_out !== want.pixel)
               report_mismatch("pixel_out", rsp_pixel_out, want.pixel);
            if (rsp_last_of_image !== want.last)
               report_mismatch("last_of_image", rsp_last_of_image, want.last);
         end
         results_seen++;
      end
   end

   // Watchdog: too long without any transfer ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && !rsp_stall) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int          sent;
      int          phase;
      int unsigned pick;
      bit          at_start;
      bit          quiet_phase;
      int          burst;
      logic [WIDTH_CFG_W-1:0] new_w;
      logic [ROW_W-1:0]       new_h;
      logic [PIX_W-1:0]       pix;

      foreach (line_prev[i]) begin
         line_prev[i] = '0;
         line_prev2[i] = '0;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Scripted part
      foreach (SCRIPT[i]) begin
         case (SCRIPT[i].kind)
            STEP_PIXEL: begin
               push_pixel(SCRIPT[i].value[PIX_W-1:0], SCRIPT[i].typed,
                          dither_out_type'({SCRIPT[i].pix, SCRIPT[i].last}));
            end
            STEP_WIDTH: begin
               drain_pipeline();
               write_register(REG_IMAGE_WIDTH, SCRIPT[i].value);
            end
            default: begin
               drain_pipeline();
               write_register(REG_IMAGE_HEIGHT, SCRIPT[i].value);
            end
         endcase
      end

      // Random phases. Widths grow only at the start of an image, so no
      // line-store entry is read before this image has written it.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         drain_pipeline();
         at_start = (col_pos == 0 && row_pos == 0);
         if ($urandom_range(2) != 0) begin
            pick = $urandom_range(99);
            if (!at_start)
               new_w = WIDTH_CFG_W'($urandom_range(0,
                          (eff_width() > 24) ? 24 : eff_width()));
            else if (pick < 4)
               new_w = WIDTH_CFG_W'($urandom_range(MAX_WIDTH, 8191));
            else if (pick < 12)
               new_w = WIDTH_CFG_W'($urandom_range(25, 300));
            else
               new_w = WIDTH_CFG_W'($urandom_range(0, 24));
            write_register(REG_IMAGE_WIDTH, {3'($urandom_range(7)), new_w});
         end
         if ($urandom_range(2) != 0) begin
            if ($urandom_range(99) < 5) new_h = ROW_W'($urandom_range(9, 65535));
            else new_h = ROW_W'($urandom_range(0, 8));
            write_register(REG_IMAGE_HEIGHT, new_h);
         end

         quiet_phase = (phase % 7 == 4);
         gaps_on = !quiet_phase;
         stalls_on = !quiet_phase;
         if (phase == 3) hold_pending = 1'b1;
         if (quiet_phase) burst = 150;
         else if (phase == 3) burst = 120;
         else burst = $urandom_range(8, 80);

         repeat (burst) begin
            case ($urandom_range(15))
               0:       pix = 8'd0;
               1:       pix = 8'd255;
               2:       pix = 8'd128;
               3:       pix = 8'd127;
               default: pix = PIX_W'($urandom_range(255));
            endcase
            push_pixel(pix, 1'b0, '0);
            sent++;
         end
         phase++;
      end

      // Let the tail drain, then give the pipeline time to show strays
      drain_pipeline();
      repeat (4) @(negedge clock);
      if (expected_dots.size() != 0)
         report_mismatch("results never arrived", 0, expected_dots.size());
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
